// File: design/bdlp_pkg.sv
// Shared types, codes and helpers for the button debounce and long-press block.
`default_nettype none

package bdlp_pkg;

	localparam int MASK_W     = 3;
	localparam int LEVEL_W    = 3;
	localparam int INDEX_W    = 3;
	localparam int TIME_W     = 16;
	localparam int STEP_W     = 10;
	localparam int COUNT_W    = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [2:0] {
		OP_SCAN       = 3'd0,
		OP_TAKE_PRESS = 3'd1,
		OP_TAKE_LONG  = 3'd2,
		OP_CLR_PRESS  = 3'd3,
		OP_CLR_LONG   = 3'd4
	} bdlp_op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_TIME     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL   = 2'd3;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [LEVEL_W-1:0] raw_levels;
		logic [INDEX_W-1:0] button_index;
	} bdlp_in_t;

	typedef struct packed {
		logic [MASK_W-1:0] pressed_mask;
		logic [MASK_W-1:0] long_held_mask;
		logic              event_taken;
		logic              index_invalid;
	} bdlp_out_t;

	typedef struct packed {
		logic [TIME_W-1:0] bounce_time;
		logic [TIME_W-1:0] long_press_time;
		logic [STEP_W-1:0] scan_step;
		logic              pressed_level;
	} bdlp_cfg_t;

	typedef struct packed {
		logic scan;
		logic take_press;
		logic take_long;
		logic clr_press;
		logic clr_long;
	} bdlp_cmd_t;

	typedef struct packed {
		logic pressed;
		logic long_held;
		logic taken;
	} bdlp_stat_t;

	function automatic logic [TIME_W-1:0] sat_add16(input logic [TIME_W-1:0] a,
			input logic [STEP_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W+1-STEP_W){1'b0}}, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/bdlp_button.sv
// Per-button cell: debounce timer, hold timer, long flag and event counters.
`default_nettype none

module bdlp_button (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdlp_pkg::bdlp_cmd_t  cmd,
	input  logic                 level,
	input  bdlp_pkg::bdlp_cfg_t  cfg,
	output bdlp_pkg::bdlp_stat_t stat
);
	import bdlp_pkg::*;

	logic               acc_q, last_q, long_q;
	logic [TIME_W-1:0]  bounce_q, hold_q;
	logic [COUNT_W-1:0] press_q, lcnt_q;

	logic               acc_n, last_n, long_n, taken;
	logic [TIME_W-1:0]  bounce_n, hold_n;
	logic [COUNT_W-1:0] press_n, lcnt_n;

	always_comb begin
		acc_n    = acc_q;
		last_n   = last_q;
		long_n   = long_q;
		bounce_n = bounce_q;
		hold_n   = hold_q;
		press_n  = press_q;
		lcnt_n   = lcnt_q;
		taken    = 1'b0;
		if (cmd.scan) begin
			if (last_q != level) begin
				bounce_n = '0;
				last_n   = level;
			end else if (acc_q != level) begin
				if (bounce_q < cfg.bounce_time) begin
					bounce_n = sat_add16(bounce_q, cfg.scan_step);
				end else begin
					acc_n = level;
					if (level == cfg.pressed_level) begin
						if (press_q != {COUNT_W{1'b1}})
							press_n = press_q + 1'b1;
					end else begin
						long_n = 1'b0;
						hold_n = '0;
					end
				end
			end else if (acc_q == cfg.pressed_level) begin
				if (hold_q < cfg.long_press_time) begin
					hold_n = sat_add16(hold_q, cfg.scan_step);
				end else if (!long_q) begin
					if (lcnt_q != {COUNT_W{1'b1}})
						lcnt_n = lcnt_q + 1'b1;
					long_n = 1'b1;
				end
			end
		end else if (cmd.take_press) begin
			if (press_q != '0) begin
				press_n = press_q - 1'b1;
				taken   = 1'b1;
			end
		end else if (cmd.take_long) begin
			if (lcnt_q != '0) begin
				lcnt_n = lcnt_q - 1'b1;
				taken  = 1'b1;
			end
		end else if (cmd.clr_press) begin
			press_n = '0;
		end else if (cmd.clr_long) begin
			lcnt_n = '0;
		end
		stat.pressed   = (acc_n == cfg.pressed_level);
		stat.long_held = long_n;
		stat.taken     = taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= 1'b1;
			last_q   <= 1'b1;
			long_q   <= 1'b0;
			bounce_q <= '0;
			hold_q   <= '0;
			press_q  <= '0;
			lcnt_q   <= '0;
		end else begin
			acc_q    <= acc_n;
			last_q   <= last_n;
			long_q   <= long_n;
			bounce_q <= bounce_n;
			hold_q   <= hold_n;
			press_q  <= press_n;
			lcnt_q   <= lcnt_n;
		end
	end

endmodule

`default_nettype wire

// File: design/button_debounce_long_press_core.sv
// Top level: input register, per-button cells, result register and config registers.
//
// Input channel in_valid/in_stall/in_word carries one command word: a scan of
// all raw levels, or a take/clear of one button's press or long event counter.
// Output channel out_valid/out_stall/out_word returns exactly one result word
// per command: debounced pressed mask, long-held mask, event_taken and
// index_invalid, all reflecting the state after that command.
// A word passes through the input register, then the result register, before out_valid
// rises. Throughput is one word per cycle while out_stall is low; the per-button cells
// update their timers and counters in the single cycle a word leaves the
// input register, so the next word sees the new state.
// When out_stall is held, the result register keeps its word and one more
// input word is taken into the input register; in_stall rises after that.
// Config writes (cfg_we, cfg_index, cfg_data) are registered, with no
// read-back, and are expected only while the block is idle.
// Reset clears all words in flight, restores the default timing config and
// puts every button in the released state with empty counters.
`default_nettype none

module button_debounce_long_press_core #(
	parameter int NUM_BUTTONS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  bdlp_pkg::bdlp_in_t                   in_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output bdlp_pkg::bdlp_out_t                  out_word,
	input  logic                                 cfg_we,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bdlp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bdlp_pkg::*;

	bdlp_cfg_t cfg_q;
	logic      valid_s1;
	bdlp_in_t  word_s1;
	logic      out_valid_q;
	bdlp_out_t out_word_q;
	logic      fire;
	logic      op_scan, op_take_p, op_take_l, op_clr_p, op_clr_l, op_indexed;
	logic      idx_ok;
	logic [NUM_BUTTONS-1:0] taken_vec, pressed_vec, long_vec;
	bdlp_out_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bounce_time     <= 16'd50;
			cfg_q.long_press_time <= 16'd1000;
			cfg_q.scan_step       <= 10'd10;
			cfg_q.pressed_level   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOUNCE_TIME:     cfg_q.bounce_time     <= cfg_data;
				CFG_LONG_PRESS_TIME: cfg_q.long_press_time <= cfg_data;
				CFG_SCAN_STEP:       cfg_q.scan_step       <= cfg_data[STEP_W-1:0];
				CFG_PRESSED_LEVEL:   cfg_q.pressed_level   <= cfg_data[0];
			endcase
		end
	end

	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			word_s1 <= in_word;
	end

	always_comb begin
		op_scan    = 1'b0;
		op_take_p  = 1'b0;
		op_take_l  = 1'b0;
		op_clr_p   = 1'b0;
		op_clr_l   = 1'b0;
		unique case (word_s1.opcode)
			OP_SCAN:       op_scan   = 1'b1;
			OP_TAKE_PRESS: op_take_p = 1'b1;
			OP_TAKE_LONG:  op_take_l = 1'b1;
			OP_CLR_PRESS:  op_clr_p  = 1'b1;
			OP_CLR_LONG:   op_clr_l  = 1'b1;
			default: ;
		endcase
		op_indexed = op_take_p || op_take_l || op_clr_p || op_clr_l;
	end

	assign idx_ok = word_s1.button_index < INDEX_W'(NUM_BUTTONS);

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		bdlp_cmd_t  cmd;
		bdlp_stat_t stat;
		logic       sel;
		logic       level;

		assign sel = fire && idx_ok && (word_s1.button_index == INDEX_W'(i));
		assign cmd.scan       = fire && op_scan;
		assign cmd.take_press = sel && op_take_p;
		assign cmd.take_long  = sel && op_take_l;
		assign cmd.clr_press  = sel && op_clr_p;
		assign cmd.clr_long   = sel && op_clr_l;

		if (i < LEVEL_W) begin : g_lvl
			assign level = word_s1.raw_levels[i];
		end else begin : g_nolvl
			assign level = 1'b0;
		end

		bdlp_button u_btn (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.level  (level),
			.cfg    (cfg_q),
			.stat   (stat)
		);

		assign taken_vec[i]   = stat.taken;
		assign pressed_vec[i] = stat.pressed;
		assign long_vec[i]    = stat.long_held;
	end

	for (genvar b = 0; b < MASK_W; b++) begin : g_mask
		if (b < NUM_BUTTONS) begin : g_on
			assign result.pressed_mask[b]   = pressed_vec[b];
			assign result.long_held_mask[b] = long_vec[b];
		end else begin : g_off
			assign result.pressed_mask[b]   = 1'b0;
			assign result.long_held_mask[b] = 1'b0;
		end
	end

	assign result.event_taken   = |taken_vec;
	assign result.index_invalid = op_indexed && !idx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_word_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	a_invalid_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_word_q.index_invalid && out_word_q.event_taken))
		else $error("index_invalid and event_taken both set");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result register not loaded after fire");

	a_taken_only_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && result.event_taken) |->
			(word_s1.opcode == OP_TAKE_PRESS || word_s1.opcode == OP_TAKE_LONG))
		else $error("event taken by a non-take opcode");
`endif

endmodule

`default_nettype wire
